[sv/u8wrap_pkg.sv]
// package for the utf-8 codepoint line wrapper
// transaction payload types, byte constants and the lead byte decode
// no dependencies
package u8wrap_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_done;
    } t_out_item;

    localparam logic [7:0] LEAD_2B_MIN      = 8'h80;
    localparam logic [7:0] LEAD_3B_MIN      = 8'hE0;
    localparam logic [7:0] LEAD_4B_MIN      = 8'hF0;
    localparam logic [7:0] ASCII_SPACE      = 8'h20;
    localparam logic [7:0] ASCII_LF         = 8'h0A;
    localparam logic [7:0] MAX_PER_LINE_RST = 8'd42;

    // continuation bytes that follow a lead byte
    function automatic logic [1:0] cont_bytes(input logic [7:0] lead);
        logic [1:0] res;
        priority if (lead < LEAD_2B_MIN) begin
            res = 2'd0;
        end else if (lead < LEAD_3B_MIN) begin
            res = 2'd1;
        end else if (lead < LEAD_4B_MIN) begin
            res = 2'd2;
        end else begin
            res = 2'd3;
        end
        return res;
    endfunction

endpackage

[sv/utf8_codepoint_line_wrapper.sv]
// utf-8 codepoint line wrapper, top level
// one byte in, one or two result transactions out
// depends on u8wrap_pkg
//
// usage:
//   input channel i_in_valid / o_in_stall carries one utf-8 byte and a
//   text_end flag; output channel o_out_valid / i_out_stall carries the
//   emitted byte, a byte_valid flag (0 for a dropped space), run_last on the
//   final result of an input and text_done on the final result of a text.
//   i_cfg_we / i_cfg_wdata sets max_per_line (0 disables wrapping); write it
//   only while no transaction is in flight.
// output: a result is loaded into the output register as its input is
//   accepted; the second result of a hard break waits in the pending slot.
// throughput: one byte per cycle while the receiver does not stall; a byte
//   that needs a newline inserted before it also fills the pending slot.
// stall: when the receiver stalls, the output register holds its result and
//   the stall passes straight back to the input channel; a pending second
//   result also stalls the input until it moves into the output register.
// reset: synchronous active low; clears the line count, continuation count,
//   space skipping, both valid flags and loads max_per_line with 42.
module utf8_codepoint_line_wrapper #(
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8wrap_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8wrap_pkg::t_out_item o_out_item
);
    import u8wrap_pkg::*;

    // compare width covers both the counter and the 8-bit limit, plus headroom
    localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS + 1 : 9;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << COUNT_BITS) - 1);

    // configuration and line state
    logic [7:0]            r_max_per_line;
    logic [COUNT_BITS-1:0] r_line_count, n_line_count;
    logic [1:0]            r_cont_left, n_cont_left;
    logic                  r_skip_spaces, n_skip_spaces;

    // output register and the pending second result
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_pend_valid;
    t_out_item r_pend;

    // per-byte decode
    logic            in_accept;
    logic            out_load;
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] cnt_ext;
    logic            is_space;
    logic            is_break;
    logic            has_second;
    t_out_item       first_res;
    t_out_item       second_res;
    logic [7:0]      res_a_byte;
    logic            res_a_valid;

    // output register free this cycle
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend_valid || !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // limit clamped to the counter range
    always_comb begin
        cnt_ext = CMP_W'(r_line_count);
        if (CMP_W'(r_max_per_line) > CNT_MAX) begin
            lim = CNT_MAX;
        end else begin
            lim = CMP_W'(r_max_per_line);
        end
    end

    assign is_space = (i_in_item.in_byte == ASCII_SPACE);
    assign is_break = is_space || (i_in_item.in_byte == ASCII_LF);

    // wrap decision: first result, optional second result and next state
    always_comb begin
        n_line_count  = r_line_count;
        n_cont_left   = r_cont_left;
        n_skip_spaces = r_skip_spaces;
        res_a_byte    = i_in_item.in_byte;
        res_a_valid   = 1'b1;
        has_second    = 1'b0;

        priority if (r_max_per_line == 8'd0) begin
            // wrapping off, byte passes unchanged
        end else if (r_cont_left != 2'd0) begin
            n_cont_left = r_cont_left - 2'd1;
        end else if (r_skip_spaces && is_space) begin
            // dropped space after a hard break
            res_a_byte  = 8'd0;
            res_a_valid = 1'b0;
        end else begin
            n_skip_spaces = 1'b0;
            if (cnt_ext >= lim) begin
                // line full: newline first
                res_a_byte   = ASCII_LF;
                n_line_count = '0;
                if (is_space) begin
                    n_skip_spaces = 1'b1;
                end else begin
                    has_second   = 1'b1;
                    n_line_count = COUNT_BITS'(1);
                    n_cont_left  = cont_bytes(i_in_item.in_byte);
                end
            end else if (r_line_count != '0 && (cnt_ext + CMP_W'(2)) >= lim && is_break) begin
                // near the limit, a space or newline becomes the break
                res_a_byte   = ASCII_LF;
                n_line_count = '0;
            end else begin
                n_line_count = r_line_count + COUNT_BITS'(1);
                n_cont_left  = cont_bytes(i_in_item.in_byte);
            end
        end

        if (i_in_item.text_end) begin
            n_line_count  = '0;
            n_cont_left   = 2'd0;
            n_skip_spaces = 1'b0;
        end

        first_res.out_byte   = res_a_byte;
        first_res.byte_valid = res_a_valid;
        first_res.run_last   = !has_second;
        first_res.text_done  = !has_second && i_in_item.text_end;

        second_res.out_byte   = i_in_item.in_byte;
        second_res.byte_valid = 1'b1;
        second_res.run_last   = 1'b1;
        second_res.text_done  = i_in_item.text_end;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_line <= MAX_PER_LINE_RST;
        end else if (i_cfg_we) begin
            r_max_per_line <= i_cfg_wdata;
        end
    end

    // line state, updated once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count  <= '0;
            r_cont_left   <= 2'd0;
            r_skip_spaces <= 1'b0;
        end else if (in_accept) begin
            r_line_count  <= n_line_count;
            r_cont_left   <= n_cont_left;
            r_skip_spaces <= n_skip_spaces;
        end
    end

    // output register with the pending slot feeding it first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_load) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
                r_pend_valid <= in_accept && has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (in_accept) begin
                r_out  <= first_res;
                r_pend <= second_res;
            end
        end
    end

endmodule

[test/tb_top.sv]
// testbench for utf8_codepoint_line_wrapper: random utf-8 texts under several line limits
// an in-file scoreboard predicts every result transaction and checks them in order
// depends on u8wrap_pkg and the utf8_codepoint_line_wrapper rtl
class wrap_scoreboard;
    // predicted result transactions, oldest first
    u8wrap_pkg::t_out_item expected_out[$];
    int                    errors;
    int unsigned           cnt_max;
    // line state as the block should hold it
    logic [7:0]            limit;
    int unsigned           line_cnt;
    int unsigned           cont_left;
    bit                    skipping;

    function new(int count_bits);
        cnt_max   = (1 << count_bits) - 1;
        limit     = u8wrap_pkg::MAX_PER_LINE_RST;
        line_cnt  = 0;
        cont_left = 0;
        skipping  = 0;
        errors    = 0;
    endfunction

    function void set_limit(logic [7:0] v);
        limit = v;
    endfunction

    function u8wrap_pkg::t_out_item mk(logic [7:0] b, logic vld);
        u8wrap_pkg::t_out_item r;
        r.out_byte   = b;
        r.byte_valid = vld;
        r.run_last   = 1'b0;
        r.text_done  = 1'b0;
        return r;
    endfunction

    // note an accepted input transaction and queue the results it causes
    function void note_byte(u8wrap_pkg::t_in_item it);
        u8wrap_pkg::t_out_item res[$];
        int unsigned           lim;
        int unsigned           seq_len;
        bit                    is_space;
        bit                    is_break;
        lim      = (limit > cnt_max) ? cnt_max : limit;
        is_space = (it.in_byte == u8wrap_pkg::ASCII_SPACE);
        is_break = is_space || (it.in_byte == u8wrap_pkg::ASCII_LF);
        if (it.in_byte < u8wrap_pkg::LEAD_2B_MIN) begin
            seq_len = 1;
        end else if (it.in_byte < u8wrap_pkg::LEAD_3B_MIN) begin
            seq_len = 2;
        end else if (it.in_byte < u8wrap_pkg::LEAD_4B_MIN) begin
            seq_len = 3;
        end else begin
            seq_len = 4;
        end

        if (limit == 0) begin
            res.push_back(mk(it.in_byte, 1'b1));
        end else if (cont_left > 0) begin
            res.push_back(mk(it.in_byte, 1'b1));
            cont_left--;
        end else if (skipping && is_space) begin
            // space swallowed after a hard break
            res.push_back(mk(8'h00, 1'b0));
        end else begin
            skipping = 0;
            if (line_cnt >= lim) begin
                // hard break before the codepoint
                res.push_back(mk(u8wrap_pkg::ASCII_LF, 1'b1));
                line_cnt = 0;
                if (is_space) begin
                    skipping = 1;
                end else begin
                    res.push_back(mk(it.in_byte, 1'b1));
                    line_cnt  = 1;
                    cont_left = seq_len - 1;
                end
            end else if (line_cnt > 0 && line_cnt + 2 >= lim && is_break) begin
                // soft break: space or newline near the limit becomes a newline
                res.push_back(mk(u8wrap_pkg::ASCII_LF, 1'b1));
                line_cnt = 0;
            end else begin
                res.push_back(mk(it.in_byte, 1'b1));
                line_cnt  = (line_cnt + 1) & cnt_max;
                cont_left = seq_len - 1;
            end
        end

        res[res.size()-1].run_last  = 1'b1;
        res[res.size()-1].text_done = it.text_end;
        foreach (res[k]) expected_out.push_back(res[k]);

        if (it.text_end) begin
            line_cnt  = 0;
            cont_left = 0;
            skipping  = 0;
        end
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_out(u8wrap_pkg::t_out_item got);
        u8wrap_pkg::t_out_item want;
        if (expected_out.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: byte %h valid %b last %b done %b",
                         got.out_byte, got.byte_valid, got.run_last, got.text_done);
            return;
        end
        want = expected_out.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.run_last !== want.run_last || got.text_done !== want.text_done) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected byte %h valid %b last %b done %b, got %h %b %b %b",
                         want.out_byte, want.byte_valid, want.run_last, want.text_done,
                         got.out_byte, got.byte_valid, got.run_last, got.text_done);
        end
    endfunction
endclass

module tb_top;
    import u8wrap_pkg::*;

    localparam int COUNT_BITS = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    wrap_scoreboard sb = new(COUNT_BITS);

    int         items_sent = 0;
    logic [7:0] cur_limit  = MAX_PER_LINE_RST;
    bit         in_quiet   = 0;
    bit         out_quiet  = 0;
    int         stall_left = 0;

    utf8_codepoint_line_wrapper #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // mostly short bursts, now and then a long one
    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // monitor: all handshakes are sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_limit(i_cfg_wdata);
            if (o_out_valid && !i_out_stall) sb.check_out(o_out_item);
            if (i_in_valid && !o_in_stall) sb.note_byte(i_in_item);
        end
    end

    // receiver stalls, with quiet stretches toggled at random
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!out_quiet && $urandom_range(0, 99) < 25) begin
            stall_left = burst_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // one input transaction, then at times a random gap with valid low
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        int       gap;
        it.in_byte  = b;
        it.text_end = last;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        gap = (in_quiet || $urandom_range(0, 99) < 55) ? 0 : burst_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the sender until every predicted result has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_out.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_limit    = v;
    endtask

    // one text of random codepoints, text_end on its last byte
    task automatic send_text(input int n_cp);
        logic [7:0] q[$];
        logic [7:0] lead;
        int         r;
        int         nc;
        for (int k = 0; k < n_cp; k++) begin
            r  = $urandom_range(0, 99);
            nc = 0;
            if (r < 40) begin
                lead = 8'($urandom_range(8'h21, 8'h7E));
            end else if (r < 55) begin
                lead = ASCII_SPACE;
                repeat ($urandom_range(0, 3)) q.push_back(ASCII_SPACE);
            end else if (r < 60) begin
                lead = ASCII_LF;
            end else if (r < 70) begin
                lead = 8'($urandom_range(8'hC0, 8'hDF));
                nc   = 1;
            end else if (r < 80) begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                nc   = 2;
            end else if (r < 87) begin
                lead = 8'($urandom_range(8'hF0, 8'hFF));
                nc   = 3;
            end else if (r < 92) begin
                // stray continuation byte taken as a two-byte lead
                lead = 8'($urandom_range(8'h80, 8'hBF));
                nc   = 1;
            end else if (r < 97) begin
                lead = 8'($urandom_range(8'h00, 8'h7F));
            end else begin
                // raw noise: may swallow following bytes as continuations
                lead = 8'($urandom_range(8'h00, 8'hFF));
            end
            q.push_back(lead);
            for (int j = 0; j < nc; j++)
                q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(8'h80, 8'hBF)));
        end
        // sometimes cut the text off right after a multibyte lead
        if ($urandom_range(0, 9) == 0) q.push_back(8'($urandom_range(8'hE0, 8'hFF)));
        foreach (q[k]) send_byte(q[k], k == q.size() - 1);
    endtask

    task automatic run_phase(input int quota);
        int start;
        int n_cp;
        start = items_sent;
        while (items_sent - start < quota) begin
            if ($urandom_range(0, 99) < 15) in_quiet = !in_quiet;
            if ($urandom_range(0, 99) < 5) wait_drain();
            if (cur_limit > 40) n_cp = $urandom_range(40, 140);
            else if ($urandom_range(0, 9) == 0) n_cp = $urandom_range(30, 80);
            else n_cp = $urandom_range(1, 25);
            send_text(n_cp);
        end
    endtask

    initial begin
        logic [7:0] fixed_limits[8] = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd42, 8'd2, 8'd5, 8'd8};
        logic [7:0] lim;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // run at the reset limit before any register write
        run_phase(150);

        // directed: limit 2 walks through hard and soft breaks
        write_limit(8'd2);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(ASCII_SPACE, 1'b0);    // hard break on a space
        send_byte(ASCII_SPACE, 1'b0);    // dropped while skipping
        send_byte(8'h63, 1'b0);
        send_byte(ASCII_LF, 1'b0);       // newline near the limit
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);          // hard break before a four-byte lead
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);          // stray continuation at a codepoint start
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE2, 1'b1);          // codepoint cut short by end of text
        // wrapping off: bytes pass as they are
        write_limit(8'd0);
        send_byte(ASCII_SPACE, 1'b0);
        send_byte(ASCII_LF, 1'b0);
        send_byte(8'h80, 1'b1);

        for (int p = 0; p < 12; p++) begin
            if (p < 8) lim = fixed_limits[p];
            else if ($urandom_range(0, 3) == 0) lim = 8'($urandom_range(0, 255));
            else lim = 8'($urandom_range(1, 12));
            write_limit(lim);
            run_phase(150);
        end

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_out.size() == 0) begin
            $display("PASS utf8_codepoint_line_wrapper");
        end else begin
            $display("FAIL utf8_codepoint_line_wrapper");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #40000000;
        $display("FAIL utf8_codepoint_line_wrapper");
        $finish;
    end

endmodule
